@@ src/dmc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types and constants for the direct-mapped MSI cache core.
// ----------------------------------------------------------------------------
package dmc_pkg;

    localparam int DMC_INDEX_BITS  = 12;
    localparam int DMC_OFFSET_BITS = 2;
    localparam int DMC_ADDR_W      = 32;
    localparam int DMC_DATA_W      = 32;
    localparam int DMC_REQ_W       = 3;
    localparam int DMC_STATUS_W    = 2;
    localparam int DMC_MSI_W       = 3;

    typedef enum logic [DMC_REQ_W-1:0] {
        REQ_READ      = 3'd0,
        REQ_WRITE     = 3'd1,
        REQ_FILL_RD   = 3'd2,
        REQ_FILL_WR   = 3'd3,
        REQ_GET_STATE = 3'd4,
        REQ_SET_STATE = 3'd5
    } dmc_req_t;

    typedef enum logic [DMC_STATUS_W-1:0] {
        STATUS_MISS     = 2'd0,
        STATUS_HIT      = 2'd1,
        STATUS_UPGRADE  = 2'd2,
        STATUS_ADDR_ERR = 2'd3
    } dmc_status_t;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_EXEC  = 2'd2
    } dmc_state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic clear_step;
    } dmc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
    } dmc_sts_t;

endpackage : dmc_pkg
`default_nettype wire

@@ src/dmc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : dmc_ram
`default_nettype wire

@@ src/dmc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmc_ctrl
// Sequencer: clearing pass after reset, then lookup and update per request,
// and the result beat's valid flag.
// ----------------------------------------------------------------------------
module dmc_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output dmc_pkg::dmc_cmd_t      cmd,
    input  wire dmc_pkg::dmc_sts_t sts
);
    import dmc_pkg::*;

    dmc_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.execute = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
        m_valid_next = cmd.execute ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_exec_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.execute |-> (!m_valid_reg || m_ready))
        else $error("update overwrote an untaken result beat");
    a_exec_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.execute |=> m_valid)
        else $error("update gave no result beat");
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> (!s_ready && state_reg == S_EXEC))
        else $error("second request taken while one is in flight");
    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> (!s_ready && !m_valid))
        else $error("handshake active during clearing pass");
`endif

endmodule : dmc_ctrl
`default_nettype wire

@@ src/dmc_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmc_datapath
// Request register, line RAM, MSI update logic and result register.
// ----------------------------------------------------------------------------
module dmc_datapath #(
    parameter int INDEX_BITS  = dmc_pkg::DMC_INDEX_BITS,
    parameter int OFFSET_BITS = dmc_pkg::DMC_OFFSET_BITS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire dmc_pkg::dmc_cmd_t                 cmd,
    output dmc_pkg::dmc_sts_t                      sts,
    input  wire logic [dmc_pkg::DMC_REQ_W-1:0]     s_req_type,
    input  wire logic [dmc_pkg::DMC_ADDR_W-1:0]    s_address,
    input  wire logic [dmc_pkg::DMC_DATA_W-1:0]    s_write_data,
    input  wire logic [dmc_pkg::DMC_MSI_W-1:0]     s_state_value,
    input  wire logic [dmc_pkg::DMC_MSI_W-1:0]     s_state_mask,
    output logic      [dmc_pkg::DMC_STATUS_W-1:0]  m_status,
    output logic      [dmc_pkg::DMC_DATA_W-1:0]    m_read_data,
    output logic                                   m_line_modified,
    output logic                                   m_line_shared,
    output logic                                   m_line_invalid
);
    import dmc_pkg::*;

    localparam int TAG_W  = DMC_ADDR_W - INDEX_BITS - OFFSET_BITS;
    localparam int DEPTH  = 1 << INDEX_BITS;
    localparam int WORD_W = 1 + TAG_W + DMC_DATA_W + DMC_MSI_W;
    // word layout, MSB first: loaded, tag, data, M, S, I
    localparam int POS_I   = 0;
    localparam int POS_S   = 1;
    localparam int POS_M   = 2;
    localparam int POS_DAT = DMC_MSI_W;
    localparam int POS_TAG = POS_DAT + DMC_DATA_W;
    localparam int POS_LD  = POS_TAG + TAG_W;

    // request register
    dmc_req_t                  req_reg;
    logic [DMC_ADDR_W-1:0]     addr_reg;
    logic [DMC_DATA_W-1:0]     wdata_reg;
    logic [DMC_MSI_W-1:0]      sval_reg;
    logic [DMC_MSI_W-1:0]      smask_reg;

    // result register
    logic [DMC_STATUS_W-1:0]   status_reg, status_next;
    logic [DMC_DATA_W-1:0]     rdata_reg, rdata_next;
    logic                      om_reg, om_next;
    logic                      os_reg, os_next;
    logic                      oi_reg, oi_next;

    logic [INDEX_BITS-1:0]     clear_cnt_reg, clear_cnt_next;

    logic [WORD_W-1:0]         rd_word;
    logic [WORD_W-1:0]         wr_word;
    logic [INDEX_BITS-1:0]     wr_addr;
    logic                      ram_we;

    logic [INDEX_BITS-1:0]     line_index;
    logic [TAG_W-1:0]          req_tag;
    logic                      line_loaded;
    logic [TAG_W-1:0]          line_tag;
    logic [DMC_DATA_W-1:0]     line_data;
    logic                      line_m, line_s, line_i;
    logic                      match;
    logic                      addr_zero;
    logic                      upd_line;
    logic [DMC_DATA_W-1:0]     new_data;
    logic [TAG_W-1:0]          new_tag;
    logic                      new_m, new_s, new_i;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg   <= dmc_req_t'(s_req_type);
            addr_reg  <= s_address;
            wdata_reg <= s_write_data;
            sval_reg  <= s_state_value;
            smask_reg <= s_state_mask;
        end
        if (cmd.execute) begin
            status_reg <= status_next;
            rdata_reg  <= rdata_next;
            om_reg     <= om_next;
            os_reg     <= os_next;
            oi_reg     <= oi_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_cnt_reg <= '0;
        end else begin
            clear_cnt_reg <= clear_cnt_next;
        end
    end

    assign clear_cnt_next = cmd.clear_step ? clear_cnt_reg + 1'b1 : clear_cnt_reg;
    assign sts.clear_last = (clear_cnt_reg == {INDEX_BITS{1'b1}});

    dmc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (wr_word),
        .re    (cmd.capture),
        .raddr (s_address[OFFSET_BITS +: INDEX_BITS]),
        .rdata (rd_word)
    );

    assign line_index  = addr_reg[OFFSET_BITS +: INDEX_BITS];
    assign req_tag     = addr_reg[DMC_ADDR_W-1 -: TAG_W];
    assign line_loaded = rd_word[POS_LD];
    assign line_tag    = rd_word[POS_TAG +: TAG_W];
    assign line_data   = rd_word[POS_DAT +: DMC_DATA_W];
    assign line_m      = rd_word[POS_M];
    assign line_s      = rd_word[POS_S];
    assign line_i      = rd_word[POS_I];
    assign match       = line_loaded && (line_tag == req_tag);
    assign addr_zero   = (addr_reg == '0);

    always_comb begin
        upd_line    = 1'b0;
        new_data    = line_data;
        new_tag     = line_tag;
        new_m       = line_m;
        new_s       = line_s;
        new_i       = line_i;
        status_next = STATUS_MISS;
        rdata_next  = '0;
        om_next     = 1'b0;
        os_next     = 1'b0;
        oi_next     = 1'b0;
        case (req_reg)
            REQ_READ: begin
                if (match && !line_i) begin
                    status_next = STATUS_HIT;
                    rdata_next  = line_data;
                end
            end
            REQ_WRITE: begin
                if (match && !line_i) begin
                    if (line_m) begin
                        upd_line    = 1'b1;
                        new_data    = wdata_reg;
                        new_s       = 1'b0;
                        new_i       = 1'b0;
                        status_next = STATUS_HIT;
                    end else if (line_s) begin
                        status_next = STATUS_UPGRADE;
                    end
                end
            end
            REQ_FILL_RD, REQ_FILL_WR: begin
                upd_line    = 1'b1;
                new_data    = wdata_reg;
                new_tag     = req_tag;
                new_m       = (req_reg == REQ_FILL_WR);
                new_s       = (req_reg == REQ_FILL_RD);
                new_i       = 1'b0;
                status_next = STATUS_HIT;
            end
            REQ_GET_STATE: begin
                if (addr_zero) begin
                    status_next = STATUS_ADDR_ERR;
                end else if (match) begin
                    status_next = STATUS_HIT;
                    om_next     = line_m;
                    os_next     = line_s;
                    oi_next     = line_i;
                end
            end
            REQ_SET_STATE: begin
                if (addr_zero) begin
                    status_next = STATUS_ADDR_ERR;
                end else if (match) begin
                    upd_line    = 1'b1;
                    new_m       = smask_reg[POS_M] ? sval_reg[POS_M] : line_m;
                    new_s       = smask_reg[POS_S] ? sval_reg[POS_S] : line_s;
                    new_i       = smask_reg[POS_I] ? sval_reg[POS_I] : line_i;
                    status_next = STATUS_HIT;
                end
            end
            default: begin
                // unknown request: drop, report miss
                upd_line = 1'b0;
            end
        endcase
    end

    // the clearing pass leaves every line unloaded with only I set
    assign ram_we  = cmd.clear_step || (cmd.execute && upd_line);
    assign wr_addr = cmd.clear_step ? clear_cnt_reg : line_index;
    assign wr_word = cmd.clear_step
                   ? {1'b0, {TAG_W{1'b0}}, {DMC_DATA_W{1'b0}}, 1'b0, 1'b0, 1'b1}
                   : {1'b1, new_tag, new_data, new_m, new_s, new_i};

    assign m_status        = status_reg;
    assign m_read_data     = rdata_reg;
    assign m_line_modified = om_reg;
    assign m_line_shared   = os_reg;
    assign m_line_invalid  = oi_reg;

`ifndef SYNTHESIS
    a_clear_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.clear_step && !sts.clear_last) |=> (clear_cnt_reg != '0))
        else $error("clearing pass wrapped early");
    a_no_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.clear_step && (cmd.execute || cmd.capture)))
        else $error("request handled during clearing pass");
`endif

endmodule : dmc_datapath
`default_nettype wire

@@ src/direct_mapped_msi_cache_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// direct_mapped_msi_cache_core
// Direct-mapped cache with one data word per line and explicit M, S, I bits.
// ----------------------------------------------------------------------------
// After reset the core sweeps its line RAM once, one line a cycle, and
// s_ready first rises once the sweep is done.
// Each request then reads its line from the RAM, whose read data is
// registered, and then updates the line and loads the result register,
// waiting first while an untaken result beat is held; the next request is
// taken in the cycle after that, so only one request is in flight at a time.
// A finished result waits in its register without blocking the next
// request's lookup.
// ----------------------------------------------------------------------------
module direct_mapped_msi_cache_core #(
    parameter int INDEX_BITS  = dmc_pkg::DMC_INDEX_BITS,
    parameter int OFFSET_BITS = dmc_pkg::DMC_OFFSET_BITS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [dmc_pkg::DMC_REQ_W-1:0]     s_req_type,
    input  wire logic [dmc_pkg::DMC_ADDR_W-1:0]    s_address,
    input  wire logic [dmc_pkg::DMC_DATA_W-1:0]    s_write_data,
    input  wire logic [dmc_pkg::DMC_MSI_W-1:0]     s_state_value,
    input  wire logic [dmc_pkg::DMC_MSI_W-1:0]     s_state_mask,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [dmc_pkg::DMC_STATUS_W-1:0]  m_status,
    output logic      [dmc_pkg::DMC_DATA_W-1:0]    m_read_data,
    output logic                                   m_line_modified,
    output logic                                   m_line_shared,
    output logic                                   m_line_invalid
);
    import dmc_pkg::*;

    dmc_cmd_t cmd;
    dmc_sts_t sts;

    dmc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    dmc_datapath #(
        .INDEX_BITS  (INDEX_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_req_type      (s_req_type),
        .s_address       (s_address),
        .s_write_data    (s_write_data),
        .s_state_value   (s_state_value),
        .s_state_mask    (s_state_mask),
        .m_status        (m_status),
        .m_read_data     (m_read_data),
        .m_line_modified (m_line_modified),
        .m_line_shared   (m_line_shared),
        .m_line_invalid  (m_line_invalid)
    );

endmodule : direct_mapped_msi_cache_core
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the direct-mapped MSI cache core.
// Requests run from a queue through a valid/ready driver with random gaps.
// A local copy of the tag, data and M/S/I arrays predicts each response,
// and the monitor checks every response beat field by field, in order.
// ----------------------------------------------------------------------------
module tb;
    import dmc_pkg::*;

    localparam int TAG_LSB     = DMC_INDEX_BITS + DMC_OFFSET_BITS;
    localparam int TAG_W       = DMC_ADDR_W - TAG_LSB;
    localparam int NUM_LINES   = 1 << DMC_INDEX_BITS;
    localparam int MSI_M       = 2;
    localparam int MSI_S       = 1;
    localparam int MSI_I       = 0;
    localparam int RANDOM_REQS = 750;
    localparam int TAIL_CYCLES = 64;
    localparam int CYCLE_LIMIT = 500000;

    localparam logic [DMC_REQ_W-1:0] REQ_RSVD_6 = 3'd6;
    localparam logic [DMC_REQ_W-1:0] REQ_RSVD_7 = 3'd7;

    localparam logic [DMC_ADDR_W-1:0] ADDR_TOP   = 32'hFFFF_FFFF;
    localparam logic [DMC_ADDR_W-1:0] ADDR_ALIAS = 32'h0000_3FFC;  // same index, tag zero

    typedef struct packed {
        logic [DMC_REQ_W-1:0]  req_type;
        logic [DMC_ADDR_W-1:0] address;
        logic [DMC_DATA_W-1:0] write_data;
        logic [DMC_MSI_W-1:0]  state_value;
        logic [DMC_MSI_W-1:0]  state_mask;
        logic                  drain;
    } cache_req_t;

    typedef struct packed {
        logic [DMC_STATUS_W-1:0] status;
        logic [DMC_DATA_W-1:0]   read_data;
        logic                    bit_m;
        logic                    bit_s;
        logic                    bit_i;
    } cache_resp_t;

    logic                    aclk            = 1'b0;
    logic                    aresetn         = 1'b0;
    logic                    s_valid         = 1'b0;
    logic                    s_ready;
    logic [DMC_REQ_W-1:0]    s_req_type      = '0;
    logic [DMC_ADDR_W-1:0]   s_address       = '0;
    logic [DMC_DATA_W-1:0]   s_write_data    = '0;
    logic [DMC_MSI_W-1:0]    s_state_value   = '0;
    logic [DMC_MSI_W-1:0]    s_state_mask    = '0;
    logic                    m_valid;
    logic                    m_ready         = 1'b0;
    logic [DMC_STATUS_W-1:0] m_status;
    logic [DMC_DATA_W-1:0]   m_read_data;
    logic                    m_line_modified;
    logic                    m_line_shared;
    logic                    m_line_invalid;

    // Predicted cache contents
    logic [TAG_W-1:0]      line_tag    [NUM_LINES];
    logic [DMC_DATA_W-1:0] line_data   [NUM_LINES];
    logic                  line_loaded [NUM_LINES];
    logic                  line_m      [NUM_LINES];
    logic                  line_s      [NUM_LINES];
    logic                  line_i      [NUM_LINES];

    cache_req_t  request_q[$];
    cache_resp_t response_q[$];

    int unsigned cycle_count = 0;
    int unsigned tx_gap      = 0;
    int unsigned rx_stall    = 0;
    bit          quiet_tx    = 1'b0;
    bit          quiet_rx    = 1'b0;
    bit          req_beat    = 1'b0;
    bit          resp_beat   = 1'b0;
    bit          failed      = 1'b0;

    direct_mapped_msi_cache_core i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_address       (s_address),
        .s_write_data    (s_write_data),
        .s_state_value   (s_state_value),
        .s_state_mask    (s_state_mask),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_read_data     (m_read_data),
        .m_line_modified (m_line_modified),
        .m_line_shared   (m_line_shared),
        .m_line_invalid  (m_line_invalid)
    );

    always #6 aclk = ~aclk;

    function automatic int unsigned pick_gap(bit quiet);
        if (quiet) return 0;
        if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // Apply one request to the predicted cache and return its response.
    function automatic cache_resp_t apply_request(cache_req_t rq);
        cache_resp_t              res;
        logic [DMC_INDEX_BITS-1:0] idx;
        logic [TAG_W-1:0]         tag;
        logic                     match;
        res   = '0;
        idx   = rq.address[TAG_LSB-1:DMC_OFFSET_BITS];
        tag   = rq.address[DMC_ADDR_W-1:TAG_LSB];
        match = line_loaded[idx] && (line_tag[idx] == tag);
        res.status = STATUS_MISS;
        case (rq.req_type)
            REQ_READ: begin
                if (match && !line_i[idx]) begin
                    res.status    = STATUS_HIT;
                    res.read_data = line_data[idx];
                end
            end
            REQ_WRITE: begin
                if (match && !line_i[idx]) begin
                    if (line_m[idx]) begin
                        line_data[idx] = rq.write_data;
                        line_s[idx]    = 1'b0;
                        line_i[idx]    = 1'b0;
                        res.status     = STATUS_HIT;
                    end else if (line_s[idx]) begin
                        res.status = STATUS_UPGRADE;
                    end
                end
            end
            REQ_FILL_RD, REQ_FILL_WR: begin
                line_data[idx]   = rq.write_data;
                line_tag[idx]    = tag;
                line_loaded[idx] = 1'b1;
                line_i[idx]      = 1'b0;
                line_m[idx]      = (rq.req_type == REQ_FILL_WR);
                line_s[idx]      = (rq.req_type == REQ_FILL_RD);
                res.status       = STATUS_HIT;
            end
            REQ_GET_STATE: begin
                if (rq.address == '0) begin
                    res.status = STATUS_ADDR_ERR;
                end else if (match) begin
                    res.status = STATUS_HIT;
                    res.bit_m  = line_m[idx];
                    res.bit_s  = line_s[idx];
                    res.bit_i  = line_i[idx];
                end
            end
            REQ_SET_STATE: begin
                if (rq.address == '0) begin
                    res.status = STATUS_ADDR_ERR;
                end else if (match) begin
                    if (rq.state_mask[MSI_M]) line_m[idx] = rq.state_value[MSI_M];
                    if (rq.state_mask[MSI_S]) line_s[idx] = rq.state_value[MSI_S];
                    if (rq.state_mask[MSI_I]) line_i[idx] = rq.state_value[MSI_I];
                    res.status = STATUS_HIT;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic queue_req(logic [DMC_REQ_W-1:0] req, logic [DMC_ADDR_W-1:0] addr,
                             logic [DMC_DATA_W-1:0] wdata, logic [DMC_MSI_W-1:0] sval,
                             logic [DMC_MSI_W-1:0] smask, logic drain);
        cache_req_t rq;
        rq.req_type    = req;
        rq.address     = addr;
        rq.write_data  = wdata;
        rq.state_value = sval;
        rq.state_mask  = smask;
        rq.drain       = drain;
        request_q.push_back(rq);
    endtask

    // Sample both channels, predict on request beats, check response beats.
    always @(posedge aclk) begin : watch_ports
        cache_req_t  seen;
        cache_resp_t want;
        cycle_count = cycle_count + 1;
        if (cycle_count % 200 == 0) begin
            quiet_tx = ($urandom_range(0, 3) == 0);
            quiet_rx = ($urandom_range(0, 3) == 0);
        end
        req_beat  = aresetn && s_valid && s_ready;
        resp_beat = aresetn && m_valid && m_ready;
        if (req_beat) begin
            seen.req_type    = s_req_type;
            seen.address     = s_address;
            seen.write_data  = s_write_data;
            seen.state_value = s_state_value;
            seen.state_mask  = s_state_mask;
            seen.drain       = 1'b0;
            response_q.push_back(apply_request(seen));
        end
        if (resp_beat) begin
            if (response_q.size() == 0) begin
                $error("response beat with nothing expected");
                failed = 1'b1;
            end else begin
                want = response_q.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    failed = 1'b1;
                end
                if (m_read_data !== want.read_data) begin
                    $error("read_data: expected %08h, got %08h", want.read_data, m_read_data);
                    failed = 1'b1;
                end
                if (m_line_modified !== want.bit_m) begin
                    $error("line_modified: expected %0b, got %0b", want.bit_m, m_line_modified);
                    failed = 1'b1;
                end
                if (m_line_shared !== want.bit_s) begin
                    $error("line_shared: expected %0b, got %0b", want.bit_s, m_line_shared);
                    failed = 1'b1;
                end
                if (m_line_invalid !== want.bit_i) begin
                    $error("line_invalid: expected %0b, got %0b", want.bit_i, m_line_invalid);
                    failed = 1'b1;
                end
            end
        end
    end

    // Request driver: hold the beat until taken, then idle or advance.
    always @(negedge aclk) begin : drive_requests
        cache_req_t nxt;
        if (aresetn && (!s_valid || req_beat)) begin
            if (tx_gap > 0) begin
                tx_gap  = tx_gap - 1;
                s_valid <= 1'b0;
            end else if (request_q.size() != 0
                         && !(request_q[0].drain && response_q.size() != 0)) begin
                nxt = request_q.pop_front();
                s_req_type    <= nxt.req_type;
                s_address     <= nxt.address;
                s_write_data  <= nxt.write_data;
                s_state_value <= nxt.state_value;
                s_state_mask  <= nxt.state_mask;
                s_valid       <= 1'b1;
                tx_gap = pick_gap(quiet_tx);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Response side back-pressure
    always @(negedge aclk) begin : drive_ready
        if (resp_beat) rx_stall = pick_gap(quiet_rx);
        if (rx_stall > 0) begin
            rx_stall = rx_stall - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin : timeout
        wait (cycle_count >= CYCLE_LIMIT);
        $display("** direct_mapped_msi_cache_core: FAILED **");
        $finish;
    end

    initial begin : stimulus
        logic [TAG_W-1:0]          tag_pool   [4];
        logic [DMC_INDEX_BITS-1:0] index_pool [8];
        logic [DMC_ADDR_W-1:0]     addr;
        logic [DMC_REQ_W-1:0]      req;
        int unsigned               pick;
        int unsigned               counted;

        for (int n = 0; n < NUM_LINES; n++) begin
            line_loaded[n] = 1'b0;
            line_m[n]      = 1'b0;
            line_s[n]      = 1'b0;
            line_i[n]      = 1'b1;
        end

        // Directed: empty lines, address zero, every MSI path
        queue_req(REQ_READ,      '0,         '0,           3'b000, 3'b000, 1'b0);
        queue_req(REQ_GET_STATE, '0,         '0,           3'b000, 3'b000, 1'b0);
        queue_req(REQ_SET_STATE, '0,         '0,           3'b111, 3'b111, 1'b0);
        queue_req(REQ_FILL_RD,   '0,         32'hFFFF_FFFF, 3'b000, 3'b000, 1'b0);
        queue_req(REQ_READ,      '0,         '0,           3'b000, 3'b000, 1'b0);
        queue_req(REQ_WRITE,     '0,         '0,           3'b000, 3'b000, 1'b0);
        queue_req(REQ_FILL_WR,   ADDR_TOP,   '0,           3'b000, 3'b000, 1'b0);
        queue_req(REQ_READ,      ADDR_TOP,   '0,           3'b000, 3'b000, 1'b0);
        queue_req(REQ_WRITE,     ADDR_TOP,   32'hA5A5_5A5A, 3'b000, 3'b000, 1'b0);
        queue_req(REQ_GET_STATE, ADDR_TOP,   '0,           3'b000, 3'b000, 1'b0);
        queue_req(REQ_READ,      ADDR_ALIAS, '0,           3'b000, 3'b000, 1'b0);
        queue_req(REQ_GET_STATE, ADDR_ALIAS, '0,           3'b000, 3'b000, 1'b0);
        queue_req(REQ_SET_STATE, ADDR_ALIAS, '0,           3'b111, 3'b111, 1'b0);
        queue_req(REQ_SET_STATE, ADDR_TOP,   '0,           3'b001, 3'b001, 1'b0);
        queue_req(REQ_READ,      ADDR_TOP,   '0,           3'b000, 3'b000, 1'b0);
        queue_req(REQ_WRITE,     ADDR_TOP,   32'h1234_5678, 3'b000, 3'b000, 1'b0);
        queue_req(REQ_GET_STATE, ADDR_TOP,   '0,           3'b000, 3'b000, 1'b0);
        queue_req(REQ_SET_STATE, ADDR_TOP,   '0,           3'b010, 3'b111, 1'b0);
        queue_req(REQ_WRITE,     ADDR_TOP,   32'h1234_5678, 3'b000, 3'b000, 1'b0);
        queue_req(REQ_SET_STATE, ADDR_TOP,   '0,           3'b000, 3'b111, 1'b0);
        queue_req(REQ_WRITE,     ADDR_TOP,   32'h1234_5678, 3'b000, 3'b000, 1'b0);
        queue_req(REQ_SET_STATE, ADDR_TOP,   '0,           3'b110, 3'b110, 1'b0);
        queue_req(REQ_WRITE,     ADDR_TOP,   32'h5A5A_A5A5, 3'b000, 3'b000, 1'b0);
        queue_req(REQ_GET_STATE, ADDR_TOP,   '0,           3'b000, 3'b000, 1'b1);
        queue_req(REQ_RSVD_6,    ADDR_TOP,   32'hFFFF_FFFF, 3'b111, 3'b111, 1'b0);
        queue_req(REQ_RSVD_7,    '0,         '0,           3'b000, 3'b000, 1'b0);

        // Random: a few hot lines and tags so fills, hits and upgrades meet
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        tag_pool[2] = TAG_W'($urandom());
        tag_pool[3] = TAG_W'($urandom());
        index_pool[0] = '0;
        index_pool[1] = '1;
        for (int n = 2; n < 8; n++) index_pool[n] = DMC_INDEX_BITS'($urandom());

        counted = 0;
        while (counted < RANDOM_REQS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                addr = '0;
            end else if (pick < 4) begin
                addr = $urandom();
            end else begin
                addr = {tag_pool[$urandom_range(0, 3)], index_pool[$urandom_range(0, 7)],
                        DMC_OFFSET_BITS'($urandom_range(0, (1 << DMC_OFFSET_BITS) - 1))};
            end
            pick = $urandom_range(0, 99);
            if (pick < 25)      req = REQ_READ;
            else if (pick < 50) req = REQ_WRITE;
            else if (pick < 60) req = REQ_FILL_RD;
            else if (pick < 70) req = REQ_FILL_WR;
            else if (pick < 82) req = REQ_GET_STATE;
            else if (pick < 97) req = REQ_SET_STATE;
            else                req = ($urandom_range(0, 1) != 0) ? REQ_RSVD_6 : REQ_RSVD_7;
            queue_req(req, addr, $urandom(), DMC_MSI_W'($urandom_range(0, 7)),
                      DMC_MSI_W'($urandom_range(0, 7)),
                      (counted == RANDOM_REQS / 2) || ($urandom_range(0, 149) == 0));
            if (req != REQ_RSVD_6 && req != REQ_RSVD_7) counted = counted + 1;
        end

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (request_q.size() != 0 || s_valid || response_q.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (!failed && response_q.size() == 0)
            $display("** direct_mapped_msi_cache_core: PASSED **");
        else
            $display("** direct_mapped_msi_cache_core: FAILED **");
        $finish;
    end

endmodule

@@ direct_mapped_msi_cache_core.f @@
src/dmc_pkg.sv
src/dmc_ram.sv
src/dmc_ctrl.sv
src/dmc_datapath.sv
src/direct_mapped_msi_cache_core.sv
tb/tb.sv
